FILE: rtl/core/twrm_pkg.sv
// Shared types, constants and field widths of the task wait and runtime monitor.
package twrm_pkg;

  // Field widths
  localparam int TASK_W = 10;
  localparam int TIME_W = 64;
  localparam int REQ_W  = 2;

  // Stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 144;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_ADDR_W-1:0] REG_WAIT_THR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RUN_THR  = 2'd1;

  localparam logic [TIME_W-1:0] WAIT_THR_RST = 64'd5000000;
  localparam logic [TIME_W-1:0] RUN_THR_RST  = 64'd100000000;

  // Default table depth
  localparam int TASK_SLOTS_DEF = 1024;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Report kinds
  localparam logic KIND_WAIT = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    OP_WAKE   = 2'd0,
    OP_SWITCH = 2'd1,
    OP_MARK   = 2'd2
  } op_t;

  // Queued request as classified by the front
  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] id;
    logic [TASK_W-1:0] prev;
    logic [TIME_W-1:0] now;
    logic              on;
    logic              id_ok;
    logic              prev_ok;
  } item_t;

  // Per-task flag entry
  typedef struct packed {
    logic mon;
    logic wake_v;
    logic run_v;
  } flags_t;

  // One outgoing report
  typedef struct packed {
    logic              kind;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] amount;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } report_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IN,
    ST_OUT,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/twrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in code order; read returns the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/twrm_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module twrm_front
  import twrm_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [REQ_W-1:0]  req,
  input  logic [TASK_W-1:0] task_id,
  input  logic [TASK_W-1:0] prev_task,
  input  logic [TIME_W-1:0] now_ns,
  input  logic              monitor_on,
  input  logic              clearing,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_pop
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t             queue [Q_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;
  logic              accept;
  logic              keep;
  logic              push;
  logic              id_ok;
  logic              prev_ok;
  item_t             new_item;

  // Hold off input during the clearing pass and while the queue is full
  assign s_tready = !clearing && (count != CNT_W'(Q_DEPTH));
  assign accept   = s_tvalid && s_tready;

  assign id_ok   = 32'(task_id) < TASK_SLOTS;
  assign prev_ok = 32'(prev_task) < TASK_SLOTS;

  // Classify: drop unused codes and out-of-range wakeups and marks
  always_comb begin
    unique case (op_t'(req))
      OP_WAKE:   keep = id_ok;
      OP_SWITCH: keep = 1'b1;
      OP_MARK:   keep = id_ok;
      default:   keep = 1'b0;
    endcase
  end

  always_comb begin
    new_item.op      = op_t'(req);
    new_item.id      = task_id;
    new_item.prev    = prev_task;
    new_item.now     = now_ns;
    new_item.on      = monitor_on;
    new_item.id_ok   = id_ok;
    new_item.prev_ok = prev_ok;
  end

  assign push    = accept && keep;
  assign q_valid = (count != '0);
  assign q_item  = queue[rptr];

  // Store queued words
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= new_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/twrm_back.sv
// Back end: per-task tables, wait and runtime measurement, report output register.
module twrm_back
  import twrm_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [TIME_W-1:0] wait_thr,
  input  logic [TIME_W-1:0] run_thr,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  output report_t           out_rep,
  input  logic              out_ready
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  clr_cnt;
  item_t             cur;
  logic              wait_pend;
  logic              run_pend;
  logic [TIME_W-1:0] wait_amt;
  logic [TIME_W-1:0] run_amt;

  // Table ports
  logic              flag_we;
  flags_t            flag_wdata;
  flags_t            flag_rdata;
  logic              wake_we;
  logic [TIME_W-1:0] wake_rdata;
  logic              run_we;
  logic [TIME_W-1:0] run_rdata;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;

  // Datapath
  logic              in_watched;
  logic [TIME_W-1:0] wait_val;
  logic              wait_hit;
  logic              prev_watched;
  logic [TIME_W-1:0] run_val;
  logic              run_hit;
  logic              load_out;
  logic              last_sel;

  twrm_ram #(.WIDTH($bits(flags_t)), .DEPTH(TASK_SLOTS)) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (waddr),
    .wdata (flag_wdata),
    .raddr (raddr),
    .rdata (flag_rdata)
  );

  twrm_ram #(.WIDTH(TIME_W), .DEPTH(TASK_SLOTS)) u_wake (
    .clk   (clk),
    .we    (wake_we),
    .waddr (waddr),
    .wdata (cur.now),
    .raddr (raddr),
    .rdata (wake_rdata)
  );

  twrm_ram #(.WIDTH(TIME_W), .DEPTH(TASK_SLOTS)) u_run (
    .clk   (clk),
    .we    (run_we),
    .waddr (waddr),
    .wdata (cur.now),
    .raddr (raddr),
    .rdata (run_rdata)
  );

  // Incoming task: flags and wake stamp are read in the cycle after the pop
  assign in_watched = cur.id_ok && flag_rdata.mon;
  assign wait_val   = flag_rdata.wake_v ? (cur.now - wake_rdata) : '0;
  assign wait_hit   = (cur.op == OP_SWITCH) && in_watched && (wait_val > wait_thr);

  // Outgoing task: a task switching to itself has just restarted, so no runtime
  assign prev_watched = cur.prev_ok && flag_rdata.mon && flag_rdata.run_v &&
                        (cur.prev != cur.id);
  assign run_val      = cur.now - run_rdata;
  assign run_hit      = prev_watched && (run_val > run_thr);

  assign load_out = (state == ST_EMIT) && (!out_valid || out_ready);
  assign last_sel = !(wait_pend && run_pend);
  assign clearing = (state == ST_CLEAR);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) state_next = ST_IN;
      end
      ST_IN: begin
        state_next = (cur.op == OP_SWITCH) ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        state_next = (wait_pend || run_hit) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (load_out && last_sel) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table accesses and queue pop
  always_comb begin
    q_pop      = 1'b0;
    flag_we    = 1'b0;
    flag_wdata = '0;
    wake_we    = 1'b0;
    run_we     = 1'b0;
    waddr      = IDX_W'(cur.id);
    raddr      = IDX_W'(cur.prev);
    unique case (state)
      ST_CLEAR: begin
        flag_we = 1'b1;
        waddr   = clr_cnt;
      end
      ST_IDLE: begin
        q_pop = q_valid;
        raddr = IDX_W'(q_item.id);
      end
      ST_IN: begin
        unique case (cur.op)
          OP_MARK: begin
            flag_we    = cur.id_ok;
            flag_wdata = '{mon: cur.on, wake_v: flag_rdata.wake_v,
                           run_v: flag_rdata.run_v};
          end
          OP_WAKE: begin
            flag_we    = in_watched;
            flag_wdata = '{mon: 1'b1, wake_v: 1'b1, run_v: flag_rdata.run_v};
            wake_we    = in_watched;
          end
          OP_SWITCH: begin
            flag_we    = in_watched;
            flag_wdata = '{mon: 1'b1, wake_v: flag_rdata.wake_v, run_v: 1'b1};
            wake_we    = in_watched && flag_rdata.wake_v;
            run_we     = in_watched;
          end
          default: begin
            flag_we = 1'b0;
          end
        endcase
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Sequencer state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Capture the current word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
  end

  // Hold measured amounts
  always_ff @(posedge clk) begin
    if (state == ST_IN) begin
      wait_amt <= wait_val;
    end
    if (state == ST_OUT) begin
      run_amt <= run_val;
    end
  end

  // Pending reports and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_pend <= 1'b0;
      run_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_IN) begin
        wait_pend <= wait_hit;
      end
      if (state == ST_OUT) begin
        run_pend <= run_hit;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (wait_pend) begin
          wait_pend <= 1'b0;
        end else begin
          run_pend <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rep.kind    <= wait_pend ? KIND_WAIT : KIND_RUN;
      out_rep.task_id <= wait_pend ? cur.id : cur.prev;
      out_rep.amount  <= wait_pend ? wait_amt : run_amt;
      out_rep.stamp   <= cur.now;
      out_rep.last    <= last_sel;
    end
  end

endmodule

FILE: rtl/core/task_wait_and_runtime_monitor_unit.sv
// Top level of the per-task wait and runtime monitor: ports, configuration, checks.
//
// Usage: request words arrive on the s_ stream. tuser carries the request
// kind (wakeup, context switch, mark); tdata carries the task, the outgoing
// task, the timestamp and the monitor flag. Reports leave on the m_ stream,
// wait reports before runtime reports, with tlast on the final report of a
// switch. Thresholds are written through cfg_we/cfg_addr/cfg_wdata; the
// user must do so only while the block is idle, as the block itself does
// not enforce it. Timing: a front queue of two words takes input one word
// per cycle while the back end is busy, until the queue is full. The back
// end is a sequencer over the task tables: a wakeup or mark passes through
// IDLE and IN, a switch through IDLE, IN and OUT and then EMIT for each
// report, as the tables have a single read port (incoming task, then
// outgoing task). Reset: thresholds return to their defaults and the flag
// table is swept, one entry per cycle; s_tready stays low meanwhile.
// Stall: a report waits in the output register while m_tready is low; the
// queue keeps taking words until it is full, then s_tready drops.
module task_wait_and_runtime_monitor_unit
  import twrm_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // task_id[9:0], prev_task[19:10], now_ns[83:20], monitor_on[84]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  logic [REQ_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // report_task[9:0], amount_ns[73:10], stamp_ns[137:74]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // report_kind[0]
  output logic                  m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TIME_W-1:0] wait_thr;
  logic [TIME_W-1:0] run_thr;
  logic              clearing;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  report_t           out_rep;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_thr <= WAIT_THR_RST;
      run_thr  <= RUN_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WAIT_THR: wait_thr <= cfg_wdata;
        REG_RUN_THR:  run_thr  <= cfg_wdata;
        default:      wait_thr <= wait_thr;
      endcase
    end
  end

  twrm_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .req        (s_tuser),
    .task_id    (s_tdata[9:0]),
    .prev_task  (s_tdata[19:10]),
    .now_ns     (s_tdata[83:20]),
    .monitor_on (s_tdata[84]),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  twrm_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .wait_thr  (wait_thr),
    .run_thr   (run_thr),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (m_tvalid),
    .out_rep   (out_rep),
    .out_ready (m_tready)
  );

  // Pack the report word
  assign m_tdata = {6'd0, out_rep.stamp, out_rep.amount, out_rep.task_id};
  assign m_tuser = out_rep.kind;
  assign m_tlast = out_rep.last;

  // No input word is taken while the flag table is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during table sweep");

  // A runtime report is always the final report of its switch
  a_run_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_RUN) |-> m_tlast)
    else $error("runtime report without tlast");

  // A wait report always exceeds the wait threshold
  a_wait_over_thr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_WAIT) |-> (m_tdata[73:10] > wait_thr))
    else $error("wait report at or below threshold");

  // The back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
